/* hw/rtl/sgb_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding Goertzel bin monitor package
// Shared widths, register indexes, state types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int DEF_MAX_WINDOW  = 4096;
  localparam int DEF_BIN_SLOTS   = 4;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int MIN_WINDOW = 16;
  localparam int WL_W       = 13;
  localparam int BC_W       = 3;
  localparam int TW_W       = 36;
  localparam int TW_HALF    = 18;
  localparam int TW_REGS    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 36;

  localparam int RES_W   = 40;
  localparam int PROD_W  = RES_W + TW_HALF;
  localparam int RE_W    = 44;
  localparam int SQ_IN_W = 31;
  localparam int SQ_W    = 64;
  localparam int CX_W    = 46;
  localparam int Z_W     = 18;
  localparam int MAG_W   = 16;
  localparam int PH_W    = 16;
  localparam int BIN_W   = 2;
  localparam int CNT_W   = 4;

  localparam int CORDIC_STEPS = 15;

  localparam logic [WL_W-1:0] WL_RESET = 13'd4096;
  localparam logic [BC_W-1:0] BC_RESET = 3'd1;
  localparam logic [TW_W-1:0] TW_RESET = 36'h4_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 3'd0,
    REG_BINS   = 3'd1,
    REG_TW0    = 3'd2,
    REG_TW1    = 3'd3,
    REG_TW2    = 3'd4,
    REG_TW3    = 3'd5
  } sgb_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHAIN,
    ST_POST_START,
    ST_POST_WAIT,
    ST_EMIT
  } sgb_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_UPDATE,
    CS_RE_MUL,
    CS_RE,
    CS_IM
  } sgb_cell_step_t;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_SQ_A,
    PS_SQ_B,
    PS_SQRT,
    PS_DIV,
    PS_DONE
  } sgb_post_step_t;

  typedef struct packed {
    logic                    valid;
    logic signed [RES_W-1:0] d;
  } sgb_link_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [PH_W-1:0]  phase;
  } sgb_post_res_t;

  function automatic logic [Z_W-1:0] cordic_angle(input logic [CNT_W-1:0] idx);
    logic [Z_W-1:0] a;
    unique case (idx)
      4'd0:    a = 18'd8192;
      4'd1:    a = 18'd4836;
      4'd2:    a = 18'd2555;
      4'd3:    a = 18'd1297;
      4'd4:    a = 18'd651;
      4'd5:    a = 18'd326;
      4'd6:    a = 18'd163;
      4'd7:    a = 18'd81;
      4'd8:    a = 18'd41;
      4'd9:    a = 18'd20;
      4'd10:   a = 18'd10;
      4'd11:   a = 18'd5;
      4'd12:   a = 18'd3;
      4'd13:   a = 18'd1;
      4'd14:   a = 18'd1;
      default: a = 18'd0;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/sgb_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sgb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/sgb_cell.sv */
// ----------------------------------------------------------------------------
// Resonator cell
// One Goertzel resonator with a shared multiplier; updates on the comb value
// from its neighbour, hands it on, then forms the real and imaginary parts.
// ----------------------------------------------------------------------------
module sgb_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [sgb_pkg::TW_HALF-1:0]  cos_i,
  input  logic signed [sgb_pkg::TW_HALF-1:0]  sin_i,
  input  sgb_pkg::sgb_link_t                  link_i,
  output sgb_pkg::sgb_link_t                  link_o,
  output logic                                busy_o,
  output logic signed [sgb_pkg::RE_W-1:0]     re_o,
  output logic signed [sgb_pkg::RE_W-1:0]     im_o
);
  import sgb_pkg::*;

  sgb_cell_step_t          step_r, step_nxt;
  logic signed [RES_W-1:0]  prev_r, prev2_r, d_r, ld_r;
  logic                     lvalid_r;
  logic signed [PROD_W-1:0] prod_r, prod, rnd15, rnd16;
  logic signed [PROD_W:0]   s0_full, re_full;
  logic signed [TW_HALF-1:0] coef;
  logic signed [RES_W-1:0]  opnd;
  logic signed [RE_W-1:0]   re_r, im_r;

  always_comb begin
    step_nxt = step_r;
    coef     = cos_i;
    opnd     = prev_r;
    unique case (step_r)
      CS_IDLE:   if (link_i.valid) step_nxt = CS_UPDATE;
      CS_UPDATE: step_nxt = CS_RE_MUL;
      CS_RE_MUL: begin
        opnd     = prev2_r;
        step_nxt = CS_RE;
      end
      CS_RE: begin
        coef     = sin_i;
        opnd     = prev2_r;
        step_nxt = CS_IM;
      end
      CS_IM:     step_nxt = CS_IDLE;
      default:   step_nxt = CS_IDLE;
    endcase
  end

  assign prod    = coef * opnd;
  assign rnd15   = (prod_r + PROD_W'(1 << 14)) >>> 15;
  assign rnd16   = (prod_r + PROD_W'(1 << 15)) >>> 16;
  assign s0_full = d_r + rnd15 - prev2_r;
  assign re_full = prev_r - rnd16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= CS_IDLE;
      lvalid_r <= 1'b0;
      prev_r   <= '0;
      prev2_r  <= '0;
    end else begin
      step_r   <= step_nxt;
      lvalid_r <= (step_r == CS_UPDATE);
      if (step_r == CS_UPDATE) begin
        prev2_r <= prev_r;
        prev_r  <= s0_full[RES_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    ld_r   <= d_r;
    if (step_r == CS_IDLE && link_i.valid) begin
      d_r <= link_i.d;
    end
    if (step_r == CS_RE) begin
      re_r <= re_full[RE_W-1:0];
    end
    if (step_r == CS_IM) begin
      im_r <= rnd16[RE_W-1:0];
    end
  end

  assign link_o = '{valid: lvalid_r, d: ld_r};
  assign busy_o = (step_r != CS_IDLE);
  assign re_o   = re_r;
  assign im_o   = im_r;

endmodule

/* hw/rtl/sgb_post.sv */
// ----------------------------------------------------------------------------
// Magnitude and phase unit
// Squares, two-bit-per-cycle square root, divide by the window length with
// saturation, and a 15-step CORDIC running alongside for the phase.
// ----------------------------------------------------------------------------
module sgb_post (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start_i,
  input  logic signed [sgb_pkg::RE_W-1:0]  re_i,
  input  logic signed [sgb_pkg::RE_W-1:0]  im_i,
  input  logic [sgb_pkg::WL_W-1:0]         n_i,
  output logic                             done_o,
  output sgb_pkg::sgb_post_res_t           res_o
);
  import sgb_pkg::*;

  sgb_post_step_t         step_r, step_nxt;
  logic [CNT_W-1:0]       cnt_r, cstep_r;
  logic                   cact_r;
  logic [RE_W-1:0]        ar, ai;
  logic [SQ_IN_W-1:0]     ar_r, ai_r;
  logic                   big_r, sat_r, im_zero_r, re_neg_r;
  logic [WL_W-1:0]        n_r;
  logic [2*SQ_IN_W-1:0]   sqa_r, sqb;
  logic [SQ_W-1:0]        v_r, r_r, bit_r, v_it, r_it, b_it;
  logic [WL_W-1:0]        rem_r;
  logic [WL_W:0]          rem2;
  logic [MAG_W-1:0]       low_r, q_r;
  logic signed [CX_W-1:0] x_r, y_r, xi, yi, dx, dy;
  logic signed [Z_W-1:0]  z_r, ang;

  always_comb begin
    step_nxt = step_r;
    unique case (step_r)
      PS_IDLE: if (start_i) step_nxt = PS_SQ_A;
      PS_SQ_A: step_nxt = PS_SQ_B;
      PS_SQ_B: step_nxt = PS_SQRT;
      PS_SQRT: if (cnt_r == '1) step_nxt = PS_DIV;
      PS_DIV:  if (cnt_r == '1) step_nxt = PS_DONE;
      PS_DONE: step_nxt = PS_IDLE;
      default: step_nxt = PS_IDLE;
    endcase
  end

  always_comb begin
    v_it = v_r;
    r_it = r_r;
    b_it = bit_r;
    for (int j = 0; j < 2; j++) begin
      if (v_it >= r_it + b_it) begin
        v_it = v_it - (r_it + b_it);
        r_it = (r_it >> 1) + b_it;
      end else begin
        r_it = r_it >> 1;
      end
      b_it = b_it >> 2;
    end
  end

  assign ar   = re_i[RE_W-1] ? RE_W'(-re_i) : RE_W'(re_i);
  assign ai   = im_i[RE_W-1] ? RE_W'(-im_i) : RE_W'(im_i);
  assign xi   = CX_W'(re_i);
  assign yi   = CX_W'(im_i);
  assign dx   = y_r >>> cstep_r;
  assign dy   = x_r >>> cstep_r;
  assign ang  = signed'(cordic_angle(cstep_r));
  assign rem2 = {rem_r, low_r[MAG_W-1]};
  assign sqb  = ai_r * ai_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= PS_IDLE;
      cact_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (step_r == PS_IDLE && start_i) begin
        cact_r <= 1'b1;
      end else if (cstep_r == CNT_W'(CORDIC_STEPS - 1)) begin
        cact_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (step_r)
      PS_IDLE: begin
        ar_r      <= ar[SQ_IN_W-1:0];
        ai_r      <= ai[SQ_IN_W-1:0];
        big_r     <= (|ar[RE_W-1:SQ_IN_W]) || (|ai[RE_W-1:SQ_IN_W]);
        im_zero_r <= (im_i == '0);
        re_neg_r  <= re_i[RE_W-1];
        n_r       <= n_i;
      end
      PS_SQ_A: sqa_r <= ar_r * ar_r;
      PS_SQ_B: begin
        v_r   <= SQ_W'(sqa_r) + SQ_W'(sqb);
        r_r   <= '0;
        bit_r <= SQ_W'(1) << 62;
        cnt_r <= '0;
      end
      PS_SQRT: begin
        v_r   <= v_it;
        r_r   <= r_it;
        bit_r <= b_it;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == '1) begin
          sat_r <= (r_it[2*MAG_W-1:MAG_W] >= MAG_W'(n_r));
          rem_r <= r_it[MAG_W+WL_W-1:MAG_W];
          low_r <= r_it[MAG_W-1:0];
        end
      end
      PS_DIV: begin
        cnt_r <= cnt_r + CNT_W'(1);
        low_r <= low_r << 1;
        if (rem2 >= (WL_W+1)'(n_r)) begin
          rem_r <= WL_W'(rem2 - (WL_W+1)'(n_r));
          q_r   <= {q_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_r <= rem2[WL_W-1:0];
          q_r   <= {q_r[MAG_W-2:0], 1'b0};
        end
      end
      PS_DONE: ;
      default: ;
    endcase

    if (step_r == PS_IDLE && start_i) begin
      cstep_r <= '0;
      if (re_i[RE_W-1]) begin
        x_r <= -xi;
        y_r <= -yi;
        z_r <= im_i[RE_W-1] ? -Z_W'(32768) : Z_W'(32768);
      end else begin
        x_r <= xi;
        y_r <= yi;
        z_r <= '0;
      end
    end else if (cact_r) begin
      cstep_r <= cstep_r + CNT_W'(1);
      if (y_r[CX_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - ang;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + ang;
      end
    end
  end

  assign done_o    = (step_r == PS_DONE);
  assign res_o.mag = (big_r || sat_r) ? '1 : q_r;
  assign res_o.phase = im_zero_r ? (re_neg_r ? PH_W'(16'h8000) : '0) : z_r[PH_W-1:0];

endmodule

/* hw/rtl/sliding_goertzel_bin_monitor_unit.sv */
// ----------------------------------------------------------------------------
// Sliding Goertzel bin monitor
// Sliding-window DFT over up to BIN_SLOTS bins, one result per active bin.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_sample) takes one signed sample per
// transaction; the output channel (out_*) gives one transaction per active
// bin, in bin order, with out_last_bin on the final one. No output is given
// until window_length samples have arrived.
// A sample passes the delay-line RAM, then the resonator cell chain, then
// the shared magnitude/phase unit, which runs 16 two-bit square-root steps
// and 16 divide steps per active bin. One sample is in flight at a time.
// After reset the delay line is zeroed; in_ready stays low meanwhile,
// configuration writes are taken throughout.
// A stalled receiver holds the output register and pauses the
// magnitude/phase unit; the next sample is accepted once the last result
// of the current one sits in the output register.
// ----------------------------------------------------------------------------
module sliding_goertzel_bin_monitor_unit #(
  parameter int MAX_WINDOW  = sgb_pkg::DEF_MAX_WINDOW,
  parameter int BIN_SLOTS   = sgb_pkg::DEF_BIN_SLOTS,
  parameter int SAMPLE_BITS = sgb_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sgb_pkg::BIN_W-1:0]           out_bin_number,
  output logic [sgb_pkg::MAG_W-1:0]           out_magnitude,
  output logic signed [sgb_pkg::PH_W-1:0]     out_phase,
  output logic                                out_last_bin,
  input  logic                                cfg_wr_en,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sgb_pkg::*;

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int MW    = $clog2(MAX_WINDOW + 1);
  localparam int CW    = (MW > WL_W) ? MW : WL_W;
  localparam int BW    = (BIN_SLOTS > 1) ? $clog2(BIN_SLOTS) : 1;
  localparam int ACT_W = 4;

  sgb_state_t        state_r, state_nxt;
  logic [WL_W-1:0]   wl_r, n_eff;
  logic [BC_W-1:0]   bc_r;
  logic [TW_W-1:0]   tw_r [BIN_SLOTS];
  logic [ACT_W-1:0]  act;
  logic [AW-1:0]     wp_r, wp_eff, wp_next, wcur_r, clr_r;
  logic [WL_W-1:0]   fill_r, fill_eff, fill_new;
  logic              full_r, seen_r, accept, last, load;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] ram_q, ram_wd;
  logic [AW-1:0]     ram_wa;
  logic              ram_we;
  logic              tok_valid_r;
  logic signed [RES_W-1:0] tok_d_r;
  sgb_link_t         link [BIN_SLOTS+1];
  logic [BIN_SLOTS-1:0] busy;
  logic signed [RE_W-1:0] re_c [BIN_SLOTS];
  logic signed [RE_W-1:0] im_c [BIN_SLOTS];
  logic [BW-1:0]     bin_r;
  logic              post_done;
  sgb_post_res_t     post_res;
  logic              ov_r, olast_r;
  logic [BIN_W-1:0]  obin_r;
  logic [MAG_W-1:0]  omag_r;
  logic [PH_W-1:0]   oph_r;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= WL_RESET;
      bc_r <= BC_RESET;
      for (int s = 0; s < BIN_SLOTS; s++) tw_r[s] <= TW_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_WINDOW) wl_r <= cfg_data[WL_W-1:0];
      if (cfg_index == REG_BINS)   bc_r <= cfg_data[BC_W-1:0];
      for (int s = 0; s < BIN_SLOTS; s++) begin
        if (s < TW_REGS && int'(cfg_index) == int'(REG_TW0) + s) begin
          tw_r[s] <= cfg_data[TW_W-1:0];
        end
      end
    end
  end

  always_comb begin
    if (wl_r < WL_W'(MIN_WINDOW)) begin
      n_eff = WL_W'(MIN_WINDOW);
    end else if (CW'(wl_r) > CW'(MAX_WINDOW)) begin
      n_eff = WL_W'(MAX_WINDOW);
    end else begin
      n_eff = wl_r;
    end
    if (bc_r == '0) begin
      act = ACT_W'(1);
    end else if (ACT_W'(bc_r) > ACT_W'(BIN_SLOTS)) begin
      act = ACT_W'(BIN_SLOTS);
    end else begin
      act = ACT_W'(bc_r);
    end
    wp_eff   = (CW'(wp_r) >= CW'(n_eff)) ? '0 : wp_r;
    wp_next  = (CW'(wp_eff) + CW'(1) == CW'(n_eff)) ? '0 : wp_eff + AW'(1);
    fill_eff = (fill_r > n_eff) ? n_eff : fill_r;
    fill_new = (fill_eff < n_eff) ? fill_eff + WL_W'(1) : fill_eff;
  end

  assign accept = in_valid && in_ready;
  assign last   = (ACT_W'(bin_r) == act - ACT_W'(1));
  assign load   = (state_r == ST_EMIT) && (!ov_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:      if (clr_r == AW'(MAX_WINDOW - 1)) state_nxt = ST_IDLE;
      ST_IDLE:       if (in_valid) state_nxt = ST_READ;
      ST_READ:       state_nxt = ST_CHAIN;
      ST_CHAIN: begin
        if (seen_r && !(|busy)) state_nxt = full_r ? ST_POST_START : ST_IDLE;
      end
      ST_POST_START: state_nxt = ST_POST_WAIT;
      ST_POST_WAIT:  if (post_done) state_nxt = ST_EMIT;
      ST_EMIT:       if (load) state_nxt = last ? ST_IDLE : ST_POST_START;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      tok_valid_r <= 1'b0;
      seen_r      <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok_valid_r <= (state_r == ST_READ);
      if (state_r == ST_CLEAR) clr_r <= clr_r + AW'(1);
      if (accept) begin
        wp_r   <= wp_next;
        fill_r <= fill_new;
      end
      if (state_r == ST_READ) begin
        seen_r <= 1'b0;
      end else if (link[BIN_SLOTS].valid) begin
        seen_r <= 1'b1;
      end
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
      wcur_r   <= wp_eff;
      full_r   <= (fill_new == n_eff);
    end
    if (state_r == ST_READ) begin
      tok_d_r <= RES_W'(sample_r) - RES_W'($signed(ram_q));
      bin_r   <= '0;
    end
    if (load) begin
      obin_r  <= BIN_W'(bin_r);
      omag_r  <= post_res.mag;
      oph_r   <= post_res.phase;
      olast_r <= last;
      if (!last) bin_r <= bin_r + BW'(1);
    end
  end

  // Delay line
  assign ram_we = (state_r == ST_CLEAR) || (state_r == ST_READ);
  assign ram_wa = (state_r == ST_CLEAR) ? clr_r : wcur_r;
  assign ram_wd = (state_r == ST_CLEAR) ? '0 : sample_r;

  sgb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_delay (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (accept),
    .rd_addr (wp_eff),
    .rd_data (ram_q)
  );

  // Resonator chain
  assign link[0] = '{valid: tok_valid_r, d: tok_d_r};

  for (genvar k = 0; k < BIN_SLOTS; k++) begin : g_cell
    sgb_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cos_i  (signed'(tw_r[k][TW_W-1:TW_HALF])),
      .sin_i  (signed'(tw_r[k][TW_HALF-1:0])),
      .link_i (link[k]),
      .link_o (link[k+1]),
      .busy_o (busy[k]),
      .re_o   (re_c[k]),
      .im_o   (im_c[k])
    );
  end

  sgb_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (state_r == ST_POST_START),
    .re_i    (re_c[bin_r]),
    .im_i    (im_c[bin_r]),
    .n_i     (n_eff),
    .done_o  (post_done),
    .res_o   (post_res)
  );

  assign out_valid      = ov_r;
  assign out_bin_number = obin_r;
  assign out_magnitude  = omag_r;
  assign out_phase      = oph_r;
  assign out_last_bin   = olast_r;

endmodule

/* hw/rtl/sgb_checker.sv */
// ----------------------------------------------------------------------------
// Sliding Goertzel bin monitor port checker
// Watches the top level's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module sgb_checker #(
  parameter int SAMPLE_BITS = sgb_pkg::DEF_SAMPLE_BITS
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [SAMPLE_BITS-1:0]          in_sample,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sgb_pkg::BIN_W-1:0]       out_bin_number,
  input logic [sgb_pkg::MAG_W-1:0]       out_magnitude,
  input logic [sgb_pkg::PH_W-1:0]        out_phase,
  input logic                            out_last_bin,
  input logic                            cfg_wr_en,
  input logic [sgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [sgb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bin_number) &&
    $stable(out_magnitude) && $stable(out_phase) && $stable(out_last_bin))
    else $error("result changed while stalled");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during delay-line clear");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while one is in flight");

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_sample))
    else $error("unknown sample offered");

  a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |-> !$isunknown({cfg_index, cfg_data}))
    else $error("unknown configuration write");

endmodule

bind sliding_goertzel_bin_monitor_unit sgb_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sgb_checker (.*);
